// File: rtl/lambert_checker_fragment_shader_core_defines.svh
// assertion macros for the lambert checker fragment shader core
// used by the rtl files that carry concurrent assertions
`ifndef LAMBERT_CHECKER_FRAGMENT_SHADER_CORE_DEFINES_SVH
`define LAMBERT_CHECKER_FRAGMENT_SHADER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LCFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCFS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LCFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCFS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/lcfs_pkg.sv
// shared types, constants and the palette for the fragment shader core
// no dependencies
package lcfs_pkg;

    parameter int COMPONENT_WIDTH = 16;
    parameter int FRAC_BITS       = 12;
    parameter int UNIT_BITS       = 14;
    parameter int QW              = UNIT_BITS + 1;
    parameter int UW              = QW + 1;
    parameter int CFG_IDX_W       = 2;
    parameter int KIND_W          = 16;
    parameter int COLOR_W         = 16;

    parameter int LIGHT_X_RESET = 4096;
    parameter int LIGHT_Y_RESET = 8192;
    parameter int LIGHT_Z_RESET = 6144;

    localparam logic [16:0] AMBIENT_Q16 = 17'd11796;
    localparam logic [15:0] DIFFUSE_Q16 = 16'd53740;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] CHECK_FULL  = 17'd65536;
    localparam logic [16:0] CHECK_DIM   = 17'd51118;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1,
        CFG_LIGHT_Z = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } rgb_t;

    function automatic rgb_t palette_color(input logic [1:0] kind);
        rgb_t c;
        case (kind)
            2'd0:    c = '{r: 16'd47186, g: 16'd47186, b: 16'd47186};
            2'd1:    c = '{r: 16'd19661, g: 16'd44564, b: 16'd20972};
            2'd2:    c = '{r: 16'd40632, g: 16'd26214, b: 16'd13107};
            default: c = '{r: 16'd18350, g: 16'd31457, b: 16'd49152};
        endcase
        return c;
    endfunction

endpackage

// File: rtl/lcfs_frag_if.sv
// fragment input channel: valid, ready and the fragment fields
// depends on lcfs_pkg
interface lcfs_frag_if #(
    parameter int W = lcfs_pkg::COMPONENT_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [W-1:0]           normal_x;
    logic signed [W-1:0]           normal_y;
    logic signed [W-1:0]           normal_z;
    logic signed [W-1:0]           tex_u;
    logic signed [W-1:0]           tex_v;
    logic [lcfs_pkg::KIND_W-1:0]   block_kind;

    modport source (
        output valid, normal_x, normal_y, normal_z, tex_u, tex_v, block_kind,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, tex_u, tex_v, block_kind,
        output ready
    );
endinterface

// File: rtl/lcfs_color_if.sv
// color result channel: valid, ready and the rgb fields
// depends on lcfs_pkg
interface lcfs_color_if;
    logic                         valid;
    logic                         ready;
    logic [lcfs_pkg::COLOR_W-1:0] red;
    logic [lcfs_pkg::COLOR_W-1:0] green;
    logic [lcfs_pkg::COLOR_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: rtl/lambert_checker_fragment_shader_core.sv
// lambert diffuse shading with ambient on a checker pattern, top level
// depends on lcfs_pkg, lcfs_frag_if, lcfs_color_if, lcfs_norm, defines header
// throughput: one item per cycle while no result waits; the square root and divider cell rows are fully pipelined
// a waiting result holds the whole pipeline until taken
// reset: light registers load their defaults, pipeline valid bits clear
`include "lambert_checker_fragment_shader_core_defines.svh"
module lambert_checker_fragment_shader_core #(
    parameter int COMPONENT_WIDTH = lcfs_pkg::COMPONENT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lcfs_frag_if.sink                         frag,
    lcfs_color_if.source                      color,
    input  logic                              cfg_we,
    input  logic [lcfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [COMPONENT_WIDTH-1:0]        cfg_data
);
    localparam int W        = COMPONENT_WIDTH;
    localparam int UW       = lcfs_pkg::UW;
    localparam int NORM_LAT = W + lcfs_pkg::QW + 3;

    logic en;

    // light registers
    logic [W-1:0] light_x_reg, light_y_reg, light_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= W'(lcfs_pkg::LIGHT_X_RESET);
            light_y_reg <= W'(lcfs_pkg::LIGHT_Y_RESET);
            light_z_reg <= W'(lcfs_pkg::LIGHT_Z_RESET);
        end
        else if (cfg_we)
        begin
            case (lcfs_pkg::cfg_idx_t'(cfg_index))
                lcfs_pkg::CFG_LIGHT_X: light_x_reg <= cfg_data;
                lcfs_pkg::CFG_LIGHT_Y: light_y_reg <= cfg_data;
                lcfs_pkg::CFG_LIGHT_Z: light_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // checker bit from texture coordinates
    logic [W-1:0] mag_u, mag_v;
    logic         chk_in;

    always_comb
    begin
        mag_u  = frag.tex_u[W-1] ? (~frag.tex_u + W'(1)) : frag.tex_u;
        mag_v  = frag.tex_v[W-1] ? (~frag.tex_v + W'(1)) : frag.tex_v;
        chk_in = mag_u[lcfs_pkg::FRAC_BITS-1] ^ mag_v[lcfs_pkg::FRAC_BITS-1];
    end

    // normalizers
    logic [2:0][UW-1:0] un, ul;
    logic               zn, zl;
    logic [1:0]         kind_n;
    logic               chk_l;

    lcfs_norm #(.W(W), .PW(2)) u_norm_n (
        .clk      (clk),
        .en       (en),
        .comp_in  ({frag.normal_z, frag.normal_y, frag.normal_x}),
        .pay_in   (frag.block_kind[1:0]),
        .unit_out (un),
        .zero_out (zn),
        .pay_out  (kind_n)
    );

    lcfs_norm #(.W(W), .PW(1)) u_norm_l (
        .clk      (clk),
        .en       (en),
        .comp_in  ({light_z_reg, light_y_reg, light_x_reg}),
        .pay_in   (chk_in),
        .unit_out (ul),
        .zero_out (zl),
        .pay_out  (chk_l)
    );

    logic [NORM_LAT-1:0] vpipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpipe_reg <= '0;
        else if (en)
            vpipe_reg <= {vpipe_reg[NORM_LAT-2:0], frag.valid};
    end

    // dot product terms
    logic signed [2:0][31:0] p_next, p_reg;
    logic                    z1_reg, chk1_reg, v1_reg;
    logic [1:0]              kind1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = 32'($signed(un[i]) * $signed(ul[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            z1_reg    <= zn | zl;
            chk1_reg  <= chk_l;
            kind1_reg <= kind_n;
        end
    end

    // dot sum and clamp
    logic signed [33:0] dot;
    logic [21:0]        dot_q16;
    logic [16:0]        d_next, d_reg;
    logic               chk2_reg;
    logic [1:0]         kind2_reg;

    always_comb
    begin
        dot     = 34'($signed(p_reg[0])) + 34'($signed(p_reg[1])) + 34'($signed(p_reg[2]));
        dot_q16 = dot[33:12];
        if (z1_reg || dot <= 34'sd0)
            d_next = '0;
        else if (dot_q16 > 22'(lcfs_pkg::ONE_Q16))
            d_next = lcfs_pkg::ONE_Q16;
        else
            d_next = dot_q16[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_next;
            chk2_reg  <= chk1_reg;
            kind2_reg <= kind1_reg;
        end
    end

    // shade
    logic [32:0] dprod;
    logic [16:0] sh_next, sh_reg;
    logic        chk3_reg;
    logic [1:0]  kind3_reg;

    always_comb
    begin
        dprod   = 33'(lcfs_pkg::DIFFUSE_Q16) * 33'(d_reg);
        sh_next = lcfs_pkg::AMBIENT_Q16 + dprod[32:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg    <= sh_next;
            chk3_reg  <= chk2_reg;
            kind3_reg <= kind2_reg;
        end
    end

    // base color
    lcfs_pkg::rgb_t     base;
    logic [2:0][32:0]   m_next, m_reg;
    logic               chk4_reg;

    always_comb
    begin
        base      = lcfs_pkg::palette_color(kind3_reg);
        m_next[0] = 33'(sh_reg) * 33'(base.r);
        m_next[1] = 33'(sh_reg) * 33'(base.g);
        m_next[2] = 33'(sh_reg) * 33'(base.b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= m_next;
            chk4_reg <= chk3_reg;
        end
    end

    // checker and saturate
    logic [16:0]        chk_val;
    logic [2:0][49:0]   full;
    logic [2:0][15:0]   c_next, c_reg;

    always_comb
    begin
        chk_val = chk4_reg ? lcfs_pkg::CHECK_FULL : lcfs_pkg::CHECK_DIM;
        for (int i = 0; i < 3; i++)
        begin
            full[i]   = 50'(m_reg[i]) * 50'(chk_val);
            c_next[i] = (full[i][49:32] > 18'd65535) ? 16'hFFFF : full[i][47:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c_reg <= c_next;
    end

    // valid chain after the normalizers
    logic v2_reg, v3_reg, v4_reg, v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vpipe_reg[NORM_LAT-1];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign en          = !v5_reg || color.ready;
    assign frag.ready  = en;
    assign color.valid = v5_reg;
    assign color.red   = c_reg[0];
    assign color.green = c_reg[1];
    assign color.blue  = c_reg[2];

    `LCFS_ASSERT(a_d_bound, clk, rst_n, v2_reg |-> (d_reg <= lcfs_pkg::ONE_Q16), "diffuse above one")
    `LCFS_ASSERT(a_zero_dark, clk, rst_n, (en && v1_reg && z1_reg) |=> (d_reg == '0), "zero vector lit")
    `LCFS_ASSERT(a_shade_range, clk, rst_n, v3_reg |-> (sh_reg >= lcfs_pkg::AMBIENT_Q16 && sh_reg <= lcfs_pkg::ONE_Q16), "shade out of range")
    `LCFS_ASSERT(a_stall_hold, clk, rst_n, !en |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg}), "pipeline moved in stall")
    `LCFS_NEVER(a_no_take_in_stall, clk, rst_n, color.valid && !color.ready && frag.ready, "item taken while stalled")
endmodule

// File: rtl/lcfs_sqrt_cell.sv
// one result bit of the pipelined integer square root
// depends on nothing
module lcfs_sqrt_cell #(
    parameter int W  = 16,
    parameter int B  = 0,
    parameter int PW = 1
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*W-1:0]  rem_in,
    input  logic [W-1:0]    root_in,
    input  logic [PW-1:0]   pay_in,
    output logic [2*W-1:0]  rem_out,
    output logic [W-1:0]    root_out,
    output logic [PW-1:0]   pay_out
);
    localparam int SW = 2 * W;

    logic [SW:0]   trial;
    logic          take;
    logic [SW-1:0] rem_next, rem_reg;
    logic [W-1:0]  root_next, root_reg;
    logic [PW-1:0] pay_reg;

    always_comb
    begin
        trial     = ((SW + 1)'(root_in) << (B + 1)) + ((SW + 1)'(1) << (2 * B));
        take      = {1'b0, rem_in} >= trial;
        rem_next  = take ? (rem_in - trial[SW-1:0]) : rem_in;
        root_next = take ? (root_in | (W'(1) << B)) : root_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pay_reg  <= pay_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign pay_out  = pay_reg;
endmodule

// File: rtl/lcfs_div_cell.sv
// one quotient bit of three restoring dividers sharing a divisor
// depends on lcfs_pkg
module lcfs_div_cell #(
    parameter int W  = lcfs_pkg::COMPONENT_WIDTH,
    parameter int K  = 0,
    parameter int PW = 1
) (
    input  logic                                             clk,
    input  logic                                             en,
    input  logic [W-1:0]                                     len_in,
    input  logic [2:0][W+lcfs_pkg::UNIT_BITS:0]              rem_in,
    input  logic [2:0][lcfs_pkg::QW-1:0]                     q_in,
    input  logic [PW-1:0]                                    pay_in,
    output logic [W-1:0]                                     len_out,
    output logic [2:0][W+lcfs_pkg::UNIT_BITS:0]              rem_out,
    output logic [2:0][lcfs_pkg::QW-1:0]                     q_out,
    output logic [PW-1:0]                                    pay_out
);
    localparam int DW = W + lcfs_pkg::UNIT_BITS + 1;
    localparam int QW = lcfs_pkg::QW;

    logic [DW-1:0]         dsh;
    logic [2:0][DW-1:0]    rem_next, rem_reg;
    logic [2:0][QW-1:0]    q_next, q_reg;
    logic [W-1:0]          len_reg;
    logic [PW-1:0]         pay_reg;

    always_comb
    begin
        dsh = DW'(len_in) << K;
        for (int i = 0; i < 3; i++)
        begin
            if (rem_in[i] >= dsh)
            begin
                rem_next[i] = rem_in[i] - dsh;
                q_next[i]   = q_in[i] | (QW'(1) << K);
            end
            else
            begin
                rem_next[i] = rem_in[i];
                q_next[i]   = q_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            len_reg <= len_in;
            pay_reg <= pay_in;
        end
    end

    assign len_out = len_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign pay_out = pay_reg;
endmodule

// File: rtl/lcfs_norm.sv
// vector normalizer: squares, sum, square root cells, divider cells, sign
// depends on lcfs_pkg, lcfs_sqrt_cell, lcfs_div_cell
module lcfs_norm #(
    parameter int W  = lcfs_pkg::COMPONENT_WIDTH,
    parameter int PW = 1
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [2:0][W-1:0]                  comp_in,
    input  logic [PW-1:0]                      pay_in,
    output logic [2:0][lcfs_pkg::UW-1:0]       unit_out,
    output logic                               zero_out,
    output logic [PW-1:0]                      pay_out
);
    localparam int SW = 2 * W;
    localparam int QW = lcfs_pkg::QW;
    localparam int UW = lcfs_pkg::UW;
    localparam int DW = W + lcfs_pkg::UNIT_BITS + 1;
    localparam int CP = PW + 3 * W + 1;
    localparam int DP = PW + 4;

    // squares
    logic [2:0][W-1:0]  mag_in;
    logic [2:0][SW-1:0] sq_next, sq_reg;
    logic [2:0][W-1:0]  c1_reg;
    logic [PW-1:0]      pay1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i]  = comp_in[i][W-1] ? (~comp_in[i] + W'(1)) : comp_in[i];
            sq_next[i] = SW'(mag_in[i]) * SW'(mag_in[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= sq_next;
            c1_reg   <= comp_in;
            pay1_reg <= pay_in;
        end
    end

    // sum of squares
    logic [SW-1:0]      s_next, s_reg;
    logic               zero2_reg;
    logic [2:0][W-1:0]  c2_reg;
    logic [PW-1:0]      pay2_reg;

    assign s_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg     <= s_next;
            zero2_reg <= (s_next == '0);
            c2_reg    <= c1_reg;
            pay2_reg  <= pay1_reg;
        end
    end

    // square root chain
    logic [W:0][SW-1:0] rem_w;
    logic [W:0][W-1:0]  root_w;
    logic [W:0][CP-1:0] spay_w;

    assign rem_w[0]  = s_reg;
    assign root_w[0] = '0;
    assign spay_w[0] = {pay2_reg, c2_reg, zero2_reg};

    for (genvar j = 0; j < W; j++)
    begin : g_sqrt
        lcfs_sqrt_cell #(.W(W), .B(W - 1 - j), .PW(CP)) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (rem_w[j]),
            .root_in  (root_w[j]),
            .pay_in   (spay_w[j]),
            .rem_out  (rem_w[j+1]),
            .root_out (root_w[j+1]),
            .pay_out  (spay_w[j+1])
        );
    end

    logic [PW-1:0]      pay3;
    logic [2:0][W-1:0]  c3;
    logic               zero3;
    logic [2:0][W-1:0]  mag3;
    logic [2:0]         sign3;

    assign {pay3, c3, zero3} = spay_w[W];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sign3[i] = c3[i][W-1];
            mag3[i]  = sign3[i] ? (~c3[i] + W'(1)) : c3[i];
        end
    end

    // divider chain
    logic [QW:0][W-1:0]         dlen_w;
    logic [QW:0][2:0][DW-1:0]   drem_w;
    logic [QW:0][2:0][QW-1:0]   dq_w;
    logic [QW:0][DP-1:0]        dpay_w;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            drem_w[0][i] = DW'(mag3[i]) << lcfs_pkg::UNIT_BITS;
        end
    end

    assign dlen_w[0] = root_w[W];
    assign dq_w[0]   = '0;
    assign dpay_w[0] = {pay3, sign3, zero3};

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        lcfs_div_cell #(.W(W), .K(QW - 1 - j), .PW(DP)) u_cell (
            .clk     (clk),
            .en      (en),
            .len_in  (dlen_w[j]),
            .rem_in  (drem_w[j]),
            .q_in    (dq_w[j]),
            .pay_in  (dpay_w[j]),
            .len_out (dlen_w[j+1]),
            .rem_out (drem_w[j+1]),
            .q_out   (dq_w[j+1]),
            .pay_out (dpay_w[j+1])
        );
    end

    // sign restore
    logic [PW-1:0]       pay4;
    logic [2:0]          sign4;
    logic                zero4;
    logic [2:0][UW-1:0]  unit_next, unit_reg;
    logic                zero_reg;
    logic [PW-1:0]       pay_reg;

    assign {pay4, sign4, zero4} = dpay_w[QW];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unit_next[i] = sign4[i] ? (UW'(0) - UW'(dq_w[QW][i])) : UW'(dq_w[QW][i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= unit_next;
            zero_reg <= zero4;
            pay_reg  <= pay4;
        end
    end

    assign unit_out = unit_reg;
    assign zero_out = zero_reg;
    assign pay_out  = pay_reg;
endmodule
